// ===== hdl/frustum_side_plane_extract_unit_assert.svh =====
// Assertion macros shared by the frustum side-plane extraction RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef FRUSTUM_SIDE_PLANE_EXTRACT_UNIT_ASSERT_SVH
`define FRUSTUM_SIDE_PLANE_EXTRACT_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FSPE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fspe_pkg.sv =====
// ----------------------------------------------------------------------------
// fspe_pkg
// Widths, plane codes and shared types of the frustum side-plane extractor.
// ----------------------------------------------------------------------------
package fspe_pkg;

	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	// magnitude of an exact row sum, up to 2^DATA_W
	localparam int MAG_W    = DATA_W + 1;
	// square of a magnitude; also holds the squared normal length
	localparam int SQ_W     = 2 * MAG_W;
	// quotient bits below the saturation point
	localparam int QUO_W    = 2 * DATA_W - 2;
	localparam int ROOT_W   = DATA_W - 1;
	localparam int DVD_W    = SQ_W + 2 * FRAC_W;
	localparam int HI_W     = DVD_W - QUO_W;
	localparam int CMP_W    = (HI_W > SQ_W) ? HI_W : SQ_W;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int LANE_LAT = QUO_W + ROOT_W + 2;
	localparam int NUM_COMP = 4;

	typedef logic [1:0] plane_idx_t;

	localparam plane_idx_t PLANE_LEFT   = 2'd0;
	localparam plane_idx_t PLANE_RIGHT  = 2'd1;
	localparam plane_idx_t PLANE_BOTTOM = 2'd2;
	localparam plane_idx_t PLANE_TOP    = 2'd3;

	typedef struct packed {
		logic       vld;
		plane_idx_t idx;
		logic       degen;
		logic       last;
	} meta_t;

endpackage

// ===== hdl/fspe_lane.sv =====
// ----------------------------------------------------------------------------
// fspe_lane
// One plane component scaled by the inverse normal length: pipelined
// restoring division of v^2*2^(2F) by S, then pipelined integer square root.
// ----------------------------------------------------------------------------
module fspe_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [fspe_pkg::SQ_W-1:0]           vsq,
	input  logic                                neg,
	input  logic [fspe_pkg::SQ_W-1:0]           ssum,
	output logic signed [fspe_pkg::DATA_W-1:0]  res
);
	import fspe_pkg::*;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic [DVD_W-1:0] dvd_full;
	logic [CMP_W-1:0] hi_c;
	logic [CMP_W-1:0] s_c;

	logic [SQ_W-1:0]  rem_s [0:QUO_W];
	logic [QUO_W-1:0] dvd_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic [SQ_W-1:0]  div_s [0:QUO_W];
	logic             dsat_s [0:QUO_W];
	logic             dneg_s [0:QUO_W];

	logic [QUO_W-1:0]  rad_s   [1:ROOT_W];
	logic [SREM_W-1:0] srem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s  [1:ROOT_W];
	logic              rsat_s  [1:ROOT_W];
	logic              rneg_s  [1:ROOT_W];

	logic [DATA_W-1:0] mag_ext;
	logic signed [DATA_W-1:0] res_q;

	assign dvd_full = {vsq, (2*FRAC_W)'(0)};
	assign hi_c     = CMP_W'(dvd_full[DVD_W-1:QUO_W]);
	assign s_c      = CMP_W'(ssum);

	// entry stage: saturation test and initial partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= hi_c[SQ_W-1:0];
			dvd_s[0]  <= dvd_full[QUO_W-1:0];
			quo_s[0]  <= '0;
			div_s[0]  <= ssum;
			dsat_s[0] <= (hi_c >= s_c);
			dneg_s[0] <= neg;
		end
	end

	// one quotient bit per stage
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [SQ_W:0] trial;
		logic [SQ_W:0] diff;
		logic          ge;
		assign trial = {rem_s[k], dvd_s[k][QUO_W-1]};
		assign ge    = (trial >= {1'b0, div_s[k]});
		assign diff  = trial - {1'b0, div_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
				dvd_s[k+1]  <= {dvd_s[k][QUO_W-2:0], 1'b0};
				quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], ge};
				div_s[k+1]  <= div_s[k];
				dsat_s[k+1] <= dsat_s[k];
				dneg_s[k+1] <= dneg_s[k];
			end
		end
	end

	// one root bit per stage, two radicand bits consumed each
	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		logic [QUO_W-1:0]  rin;
		logic [SREM_W-1:0] remin;
		logic [ROOT_W-1:0] rootin;
		logic              sin;
		logic              nin;
		logic [SREM_W+1:0] trial;
		logic [SREM_W+1:0] tv;
		logic [SREM_W+1:0] diff;
		logic              ge;
		if (j == 0) begin : g_first
			assign rin    = quo_s[QUO_W];
			assign remin  = '0;
			assign rootin = '0;
			assign sin    = dsat_s[QUO_W];
			assign nin    = dneg_s[QUO_W];
		end else begin : g_next
			assign rin    = rad_s[j];
			assign remin  = srem_s[j];
			assign rootin = root_s[j];
			assign sin    = rsat_s[j];
			assign nin    = rneg_s[j];
		end
		assign trial = {remin, rin[QUO_W-1 -: 2]};
		assign tv    = (SREM_W+2)'({rootin, 2'b01});
		assign ge    = (trial >= tv);
		assign diff  = trial - tv;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1]  <= {rin[QUO_W-3:0], 2'b00};
				srem_s[j+1] <= ge ? diff[SREM_W-1:0] : trial[SREM_W-1:0];
				root_s[j+1] <= {rootin[ROOT_W-2:0], ge};
				rsat_s[j+1] <= sin;
				rneg_s[j+1] <= nin;
			end
		end
	end

	assign mag_ext = DATA_W'(root_s[ROOT_W]);

	// apply sign, clamp on overflow
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (rsat_s[ROOT_W]) begin
				res_q <= rneg_s[ROOT_W] ? SAT_MIN : SAT_MAX;
			end else if (rneg_s[ROOT_W]) begin
				res_q <= -$signed(mag_ext);
			end else begin
				res_q <= $signed(mag_ext);
			end
		end
	end

	assign res = res_q;

endmodule

// ===== hdl/frustum_side_plane_extract_unit.sv =====
// ----------------------------------------------------------------------------
// frustum_side_plane_extract_unit
// Left, right, bottom and top frustum planes from a view-projection matrix.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one beat per matrix: rows 0, 1 and 3 of each of
//   the four columns, signed fixed point. The output channel gives four beats
//   per matrix, in order left, right, bottom, top; last_plane marks the top
//   plane. Each beat holds the plane normal and distance divided by the
//   normal length, saturated; degenerate flags a zero normal with all-zero
//   values.
//   Throughput: one plane beat every cycle while the output is not stalled,
//   set by the single result channel; a matrix is held until its top plane
//   leaves. The plane math is fully pipelined. From a taken matrix to its
//   left plane, most of the delay is the per-component divider (62 stages)
//   and square root (31 stages); right, bottom and top planes follow in turn.
//   Stall: while out_stall holds a valid output beat, the whole pipeline
//   freezes; nothing is lost or repeated. in_stall rises while a matrix is
//   still being split into planes, so also while one is held and frozen.
//   Reset: arst_n clears all valid bits; the block is ready right after.
// ----------------------------------------------------------------------------
module frustum_side_plane_extract_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r3,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fspe_pkg::plane_idx_t                plane_index,
	output logic signed [fspe_pkg::DATA_W-1:0]  normal_x,
	output logic signed [fspe_pkg::DATA_W-1:0]  normal_y,
	output logic signed [fspe_pkg::DATA_W-1:0]  normal_z,
	output logic signed [fspe_pkg::DATA_W-1:0]  distance,
	output logic                                degenerate,
	output logic                                last_plane
);
	import fspe_pkg::*;

	`include "frustum_side_plane_extract_unit_assert.svh"

	// pipeline advance: freeze only when a finished beat is held back
	logic en;
	logic plane_done;
	logic in_acc;

	// held matrix, split into one plane per cycle while the pipeline advances
	logic              item_vld_q;
	plane_idx_t        cnt_q;
	logic [DATA_W-1:0] r0_q [NUM_COMP];
	logic [DATA_W-1:0] r1_q [NUM_COMP];
	logic [DATA_W-1:0] r3_q [NUM_COMP];

	logic use_row1;
	logic do_sub;

	// stage 1: exact sums as sign and magnitude
	logic [MAG_W-1:0] mag_s1 [NUM_COMP];
	logic             neg_s1 [NUM_COMP];
	meta_t            meta_s1;

	// stage 2: squares
	logic [SQ_W-1:0]  sq_s2  [NUM_COMP];
	logic             neg_s2 [NUM_COMP];
	meta_t            meta_s2;

	// stage 3: squared normal length
	logic [SQ_W+1:0]  ssum_c;
	logic [SQ_W-1:0]  sq_s3  [NUM_COMP];
	logic             neg_s3 [NUM_COMP];
	logic [SQ_W-1:0]  ssum_s3;
	meta_t            meta_s3;

	// side band that travels alongside the lanes
	meta_t            meta_p [LANE_LAT];
	logic signed [DATA_W-1:0] lane_res [NUM_COMP];

	assign en         = !out_valid || !out_stall;
	assign plane_done = item_vld_q && en && (cnt_q == PLANE_TOP);
	assign in_stall   = item_vld_q && !plane_done;
	assign in_acc     = in_valid && !in_stall;

	// hold the matrix until its four planes are split, take the next one as the top plane leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			cnt_q      <= PLANE_LEFT;
		end else begin
			if (in_acc) begin
				item_vld_q <= 1'b1;
			end else if (plane_done) begin
				item_vld_q <= 1'b0;
			end
			if (item_vld_q && en) begin
				cnt_q <= cnt_q + plane_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			r0_q[0] <= c0r0;
			r0_q[1] <= c1r0;
			r0_q[2] <= c2r0;
			r0_q[3] <= c3r0;
			r1_q[0] <= c0r1;
			r1_q[1] <= c1r1;
			r1_q[2] <= c2r1;
			r1_q[3] <= c3r1;
			r3_q[0] <= c0r3;
			r3_q[1] <= c1r3;
			r3_q[2] <= c2r3;
			r3_q[3] <= c3r3;
		end
	end

	// bottom/top use row 1, right/top subtract
	assign use_row1 = (cnt_q == PLANE_BOTTOM) || (cnt_q == PLANE_TOP);
	assign do_sub   = (cnt_q == PLANE_RIGHT)  || (cnt_q == PLANE_TOP);

	for (genvar c = 0; c < NUM_COMP; c++) begin : g_sum
		logic signed [MAG_W-1:0] a_ext;
		logic signed [MAG_W-1:0] b_ext;
		logic signed [MAG_W-1:0] s;
		assign a_ext = MAG_W'($signed(r3_q[c]));
		assign b_ext = use_row1 ? MAG_W'($signed(r1_q[c])) : MAG_W'($signed(r0_q[c]));
		assign s     = do_sub ? (a_ext - b_ext) : (a_ext + b_ext);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s1[c] <= s[MAG_W-1];
				mag_s1[c] <= s[MAG_W-1] ? MAG_W'(-s) : MAG_W'(s);
			end
		end
	end

	// square each component
	for (genvar c = 0; c < NUM_COMP; c++) begin : g_sq
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s2[c]  <= SQ_W'(mag_s1[c]) * SQ_W'(mag_s1[c]);
				neg_s2[c] <= neg_s1[c];
				sq_s3[c]  <= sq_s2[c];
				neg_s3[c] <= neg_s2[c];
			end
		end
	end

	assign ssum_c = (SQ_W+2)'(sq_s2[0]) + (SQ_W+2)'(sq_s2[1]) + (SQ_W+2)'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			ssum_s3 <= ssum_c[SQ_W-1:0];
		end
	end

	// side band through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
			meta_s2 <= '0;
			meta_s3 <= '0;
		end else if (en) begin
			meta_s1 <= '{vld: item_vld_q, idx: cnt_q, degen: 1'b0,
				last: (cnt_q == PLANE_TOP)};
			meta_s2 <= meta_s1;
			meta_s3 <= '{vld: meta_s2.vld, idx: meta_s2.idx, degen: (ssum_c == '0),
				last: meta_s2.last};
		end
	end

	// one scaling lane per component: x, y, z, distance
	for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
		fspe_lane u_lane (
			.clk  (clk),
			.en   (en),
			.vsq  (sq_s3[c]),
			.neg  (neg_s3[c]),
			.ssum (ssum_s3),
			.res  (lane_res[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++) begin
				meta_p[k] <= '0;
			end
		end else if (en) begin
			meta_p[0] <= meta_s3;
			for (int k = 1; k < LANE_LAT; k++) begin
				meta_p[k] <= meta_p[k-1];
			end
		end
	end

	// output register: drop values of a zero-length normal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= meta_p[LANE_LAT-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plane_index <= meta_p[LANE_LAT-1].idx;
			degenerate  <= meta_p[LANE_LAT-1].degen;
			last_plane  <= meta_p[LANE_LAT-1].last;
			normal_x    <= meta_p[LANE_LAT-1].degen ? '0 : lane_res[0];
			normal_y    <= meta_p[LANE_LAT-1].degen ? '0 : lane_res[1];
			normal_z    <= meta_p[LANE_LAT-1].degen ? '0 : lane_res[2];
			distance    <= meta_p[LANE_LAT-1].degen ? '0 : lane_res[3];
		end
	end

	`FSPE_ASSERT_IMPL(a_degen_zero, out_valid && degenerate, (normal_x == '0) && (normal_y == '0) && (normal_z == '0) && (distance == '0), "degenerate plane with nonzero values")
	`FSPE_ASSERT_IMPL(a_last_top, out_valid, last_plane == (plane_index == PLANE_TOP), "last_plane not on top plane")
	`FSPE_ASSERT_IMPL(a_take_at_top, item_vld_q && !in_stall, cnt_q == PLANE_TOP, "new matrix taken before top plane")
	`FSPE_ASSERT_NEXT(a_accept_holds, in_valid && !in_stall, item_vld_q, "accepted matrix not held")

endmodule

// ===== bench/frustum_side_plane_extract_unit_chk.sv =====
// ----------------------------------------------------------------------------
// frustum_side_plane_extract_unit_chk
// Watches both channels, predicts the four side planes of every matrix and
// compares each plane beat with the oldest expected one.
// ----------------------------------------------------------------------------
module frustum_side_plane_extract_unit_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c0r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c1r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c2r3,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r0,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r1,
	input  logic signed [fspe_pkg::DATA_W-1:0]  c3r3,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  fspe_pkg::plane_idx_t                plane_index,
	input  logic signed [fspe_pkg::DATA_W-1:0]  normal_x,
	input  logic signed [fspe_pkg::DATA_W-1:0]  normal_y,
	input  logic signed [fspe_pkg::DATA_W-1:0]  normal_z,
	input  logic signed [fspe_pkg::DATA_W-1:0]  distance,
	input  logic                                degenerate,
	input  logic                                last_plane,
	output int                                  fail_count,
	output int                                  planes_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import fspe_pkg::*;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct {
		plane_idx_t idx;
		word_t      comp[4];
		logic       degen;
		logic       last;
	} plane_t;

	plane_t expected_planes[$];
	int     errs;

	assign fail_count     = errs;
	assign planes_pending = expected_planes.size();

	// truncated |v| * 2^FRAC / sqrt(s), saturated, with the sign of v
	function automatic word_t scale_comp(logic [DATA_W:0] mag, logic neg, logic [191:0] s);
		logic [191:0] t;
		logic [191:0] p;
		logic [DATA_W-1:0] m;
		logic [DATA_W-1:0] cand;
		t = (192'(mag) * 192'(mag)) << (2 * FRAC_W);
		m = '0;
		for (int b = DATA_W - 1; b >= 0; b--) begin
			cand = m | (DATA_W'(1) << b);
			p = 192'(cand) * 192'(cand) * s;
			if (p <= t)
				m = cand;
		end
		if (neg) begin
			if (m > {1'b1, {(DATA_W-1){1'b0}}})
				m = {1'b1, {(DATA_W-1){1'b0}}};
			return -m;
		end
		if (m > {1'b0, {(DATA_W-1){1'b1}}})
			m = {1'b0, {(DATA_W-1){1'b1}}};
		return m;
	endfunction

	// push the left, right, bottom and top planes of one matrix
	task automatic predict_planes(input word_t mat[12]);
		logic signed [DATA_W+1:0] sum;
		logic [DATA_W:0] mag[4];
		logic neg[4];
		logic [191:0] s;
		logic sub;
		int row;
		plane_t pl;
		for (int p = 0; p < 4; p++) begin
			row = (p < 2) ? 0 : 1;
			sub = (p % 2) == 1;
			s = '0;
			for (int c = 0; c < 4; c++) begin
				if (sub)
					sum = $signed({{2{mat[3*c+2][DATA_W-1]}}, mat[3*c+2]})
						- $signed({{2{mat[3*c+row][DATA_W-1]}}, mat[3*c+row]});
				else
					sum = $signed({{2{mat[3*c+2][DATA_W-1]}}, mat[3*c+2]})
						+ $signed({{2{mat[3*c+row][DATA_W-1]}}, mat[3*c+row]});
				neg[c] = sum < 0;
				mag[c] = (DATA_W+1)'(neg[c] ? (-sum) : sum);
				if (c < 3)
					s = s + 192'(mag[c]) * 192'(mag[c]);
			end
			pl.idx = plane_idx_t'(p);
			pl.degen = (s == '0);
			pl.last = (pl.idx == PLANE_TOP);
			for (int c = 0; c < 4; c++)
				pl.comp[c] = pl.degen ? '0 : scale_comp(mag[c], neg[c], s);
			expected_planes.push_back(pl);
		end
	endtask

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t: mismatch %s: expected %0h got %0h", $realtime, what, want, got);
		errs++;
	endtask

	initial errs = 0;

	always @(posedge clk) begin
		plane_t e;
		word_t mat[12];
		if (arst_n && in_valid && !in_stall) begin
			mat = '{c0r0, c0r1, c0r3, c1r0, c1r1, c1r3, c2r0, c2r1, c2r3, c3r0, c3r1, c3r3};
			predict_planes(mat);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_planes.size() == 0) begin
				report("unexpected beat", 0, plane_index);
			end else begin
				e = expected_planes.pop_front();
				if (plane_index != e.idx) report("plane_index", e.idx, plane_index);
				if (normal_x != e.comp[0]) report("normal_x", e.comp[0], normal_x);
				if (normal_y != e.comp[1]) report("normal_y", e.comp[1], normal_y);
				if (normal_z != e.comp[2]) report("normal_z", e.comp[2], normal_z);
				if (distance != e.comp[3]) report("distance", e.comp[3], distance);
				if (degenerate != e.degen) report("degenerate", e.degen, degenerate);
				if (last_plane != e.last) report("last_plane", e.last, last_plane);
			end
		end
	end

endmodule

// ===== bench/frustum_side_plane_extract_unit_tb.sv =====
// ----------------------------------------------------------------------------
// frustum_side_plane_extract_unit_tb
// Drives matrices into the side-plane extractor with random gaps and output
// stalls; the checker predicts and compares every plane beat.
// ----------------------------------------------------------------------------
module frustum_side_plane_extract_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fspe_pkg::*;

	typedef logic [DATA_W-1:0] word_t;

	localparam word_t ONE  = word_t'(1) << FRAC_W;
	localparam word_t WMAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WMIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam word_t WNEG = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b1;
	word_t mat_q[12];
	plane_idx_t plane_index;
	logic signed [DATA_W-1:0] normal_x, normal_y, normal_z, distance;
	logic degenerate, last_plane;
	int fail_count, planes_pending;
	// raised by the stimulus to make the receiver hold off for a long stretch
	logic long_hold = 1'b0;

	initial foreach (mat_q[i]) mat_q[i] = '0;

	always #5 clk = ~clk;

	frustum_side_plane_extract_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.c0r0(mat_q[0]), .c0r1(mat_q[1]), .c0r3(mat_q[2]),
		.c1r0(mat_q[3]), .c1r1(mat_q[4]), .c1r3(mat_q[5]),
		.c2r0(mat_q[6]), .c2r1(mat_q[7]), .c2r3(mat_q[8]),
		.c3r0(mat_q[9]), .c3r1(mat_q[10]), .c3r3(mat_q[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.plane_index(plane_index), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .distance(distance),
		.degenerate(degenerate), .last_plane(last_plane)
	);

	frustum_side_plane_extract_unit_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.c0r0(mat_q[0]), .c0r1(mat_q[1]), .c0r3(mat_q[2]),
		.c1r0(mat_q[3]), .c1r1(mat_q[4]), .c1r3(mat_q[5]),
		.c2r0(mat_q[6]), .c2r1(mat_q[7]), .c2r3(mat_q[8]),
		.c3r0(mat_q[9]), .c3r1(mat_q[10]), .c3r3(mat_q[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.plane_index(plane_index), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .distance(distance),
		.degenerate(degenerate), .last_plane(last_plane),
		.fail_count(fail_count), .planes_pending(planes_pending)
	);

	// Offer one matrix beat after a random gap and hold it until taken.
	// A zero gap keeps in_valid high, so it is never dropped and raised
	// within the same step.
	task automatic send_matrix(input word_t m[12], input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		foreach (m[i]) mat_q[i] <= m[i];
		@(posedge clk iff !in_stall);
	endtask

	// Random matrix: half small Q16.16 values like a real projection, the
	// rest full-range noise, some with a degenerate side plane.
	task automatic send_random(input bit no_gap);
		word_t m[12];
		int kind;
		int r;
		kind = $urandom_range(0, 9);
		foreach (m[i]) begin
			if (kind < 5)
				m[i] = word_t'($signed($urandom_range(0, 8 * ONE)) - 4 * $signed(ONE));
			else
				m[i] = $urandom;
		end
		// zero the normal of one plane: row 3 equals row 0 or row 1 in the first three columns
		if (kind == 9) begin
			r = $urandom_range(0, 1);
			for (int c = 0; c < 3; c++)
				m[3*c+2] = m[3*c+r];
		end
		send_matrix(m, no_gap);
	endtask

	// Receiver: stall a random number of cycles before each beat; honor a
	// long hold-off when the stimulus asks for one.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
			end
			// streaks with no stall at all
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk iff out_valid);
		end
	end

	initial begin
		word_t d[12];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all zero: every plane degenerate
		foreach (d[i]) d[i] = '0;
		send_matrix(d, 0);
		// identity projection
		d = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE};
		send_matrix(d, 0);
		// extremes everywhere
		foreach (d[i]) d[i] = WMAX;
		send_matrix(d, 0);
		foreach (d[i]) d[i] = WMIN;
		send_matrix(d, 0);
		foreach (d[i]) d[i] = WNEG;
		send_matrix(d, 1);
		d = '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN};
		send_matrix(d, 1);
		d = '{WMIN, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMIN};
		send_matrix(d, 0);
		// tiny normal, huge distance: saturate both ways
		d = '{0, 0, 1, 0, 0, 0, 0, 0, 0, WMIN, 0, WMAX};
		send_matrix(d, 0);
		d = '{0, 1, 0, 0, 0, 0, 0, 0, 0, WMAX, WMAX, WMIN};
		send_matrix(d, 0);
		// right degenerate only, left, bottom and top normal
		d = '{ONE, 3, ONE, 0, 5, 0, WNEG, 7, WNEG, 9, 11, 13};
		send_matrix(d, 0);
		// top zero through subtraction of equal negatives, the other planes normal
		d = '{1, WMIN, WMIN, 2, 0, 0, 3, WNEG, WNEG, 4, 5, 6};
		send_matrix(d, 0);
		// perspective-like matrix
		d = '{word_t'(ONE + ONE/2), 0, 0, 0, 2 * ONE, 0, 0, 0, -ONE, 0, 0, 0};
		send_matrix(d, 1);

		for (int k = 0; k < 80; k++) begin
			if (k == 40) begin
				// fill the pipeline against a frozen output
				long_hold = 1'b1;
				for (int j = 0; j < 30; j++)
					send_random(1);
				long_hold = 1'b0;
			end
			if (k == 60) begin
				// drain completely, then resume
				in_valid <= 1'b0;
				@(posedge clk);
				wait (planes_pending == 0);
				@(posedge clk);
			end
			send_random(($urandom_range(0, 3) == 0));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (planes_pending == 0);
		repeat (150) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/fspe_pkg.sv
hdl/fspe_lane.sv
hdl/frustum_side_plane_extract_unit.sv
bench/frustum_side_plane_extract_unit_chk.sv
bench/frustum_side_plane_extract_unit_tb.sv
